FILE: hw/rtl/gbiq_pkg.sv
// ----------------------------------------------------------------------------
// gbiq_pkg
// Shared types and codes of the GPIO blink and input qualifier block.
// ----------------------------------------------------------------------------
package gbiq_pkg;

  // The port field is four bits wide, so at most sixteen ports are addressable.
  localparam int MAX_PORTS = 16;
  localparam int IDX_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [7:0] FOREVER = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_PORT_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK = 1'b1;

  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_IGNORED = 1'b1;

  localparam logic [1:0] PST_INACTIVE = 2'd0;
  localparam logic [1:0] PST_ACTIVE   = 2'd1;
  localparam logic [1:0] PST_ABSENT   = 2'd2;

  typedef enum logic [2:0] {
    ACT_INIT        = 3'd0,
    ACT_SET_LEVEL   = 3'd1,
    ACT_BLINK_START = 3'd2,
    ACT_BLINK_STOP  = 3'd3,
    ACT_TICK        = 3'd4,
    ACT_SET_HOLD    = 3'd5,
    ACT_POLL        = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    MODE_ABSENT    = 2'd0,
    MODE_INPUT     = 2'd1,
    MODE_OUT_INACT = 2'd2,
    MODE_OUT_ACT   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SINGLE,
    ST_REPORT
  } state_t;

  typedef struct packed {
    action_t    action;
    logic [3:0] port;
    logic       want_active;
    logic [7:0] half_period;
    logic [7:0] blink_count;
    logic [7:0] hold_ticks;
    logic       pin_level;
  } gbiq_in_t;

  typedef struct packed {
    logic [15:0] pins_out;
    logic        status;
    logic [1:0]  port_state;
    logic        qualified;
  } gbiq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             step;
    logic             walk;
    logic             report;
    logic [IDX_W-1:0] idx;
  } gbiq_cmd_t;

endpackage

FILE: hw/rtl/gbiq_ctrl.sv
// ----------------------------------------------------------------------------
// gbiq_ctrl
// Sequencer: accepts a request, walks the ports for init and tick, steps
// once for the other actions, then has the datapath register the result.
// ----------------------------------------------------------------------------
module gbiq_ctrl #(
  parameter int NUM_PORTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  gbiq_pkg::action_t   action,
  output logic                busy,
  output gbiq_pkg::gbiq_cmd_t cmd
);

  localparam int NP = (NUM_PORTS < gbiq_pkg::MAX_PORTS) ? NUM_PORTS : gbiq_pkg::MAX_PORTS;
  localparam logic [gbiq_pkg::IDX_W-1:0] LAST_IDX = gbiq_pkg::IDX_W'(NP - 1);

  gbiq_pkg::state_t state_r, state_nxt;
  logic [gbiq_pkg::IDX_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbiq_pkg::ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cmd        = '0;
    cmd.idx    = idx_r;
    busy       = (state_r != gbiq_pkg::ST_IDLE);
    case (state_r)
      gbiq_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          idx_nxt  = '0;
          if (action == gbiq_pkg::ACT_INIT || action == gbiq_pkg::ACT_TICK) begin
            state_nxt = gbiq_pkg::ST_WALK;
          end else begin
            state_nxt = gbiq_pkg::ST_SINGLE;
          end
        end
      end
      gbiq_pkg::ST_WALK: begin
        cmd.step = 1'b1;
        cmd.walk = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = gbiq_pkg::ST_REPORT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      gbiq_pkg::ST_SINGLE: begin
        cmd.step  = 1'b1;
        state_nxt = gbiq_pkg::ST_REPORT;
      end
      gbiq_pkg::ST_REPORT: begin
        cmd.report = 1'b1;
        state_nxt  = gbiq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gbiq_pkg::ST_IDLE;
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gbiq_pkg::ST_WALK) |-> (idx_r <= LAST_IDX))
    else $error("port walk ran past the last port");

  a_report_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.report |=> !cmd.report && !busy)
    else $error("report not followed by idle");

endmodule

FILE: hw/rtl/gbiq_datapath.sv
// ----------------------------------------------------------------------------
// gbiq_datapath
// Configuration, per-port blink and hold registers, the one-port update
// logic and the result register.
// ----------------------------------------------------------------------------
module gbiq_datapath #(
  parameter int NUM_PORTS = 16,
  parameter int TIME_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gbiq_pkg::gbiq_cmd_t                 cmd,
  input  gbiq_pkg::gbiq_in_t                  in_data,
  input  logic                                cfg_we,
  input  logic [gbiq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_wdata,
  output logic                                out_strobe,
  output gbiq_pkg::gbiq_out_t                 out_data
);

  localparam int NP = (NUM_PORTS < gbiq_pkg::MAX_PORTS) ? NUM_PORTS : gbiq_pkg::MAX_PORTS;
  localparam int AW = (NP > 1) ? $clog2(NP) : 1;
  // Time fields arrive as eight bits, so no stored time needs more.
  localparam int TW = (TIME_BITS < 8) ? TIME_BITS : 8;

  logic [2*NP-1:0] port_mode_r, port_mode_nxt;
  logic [NP-1:0]   act_mask_r, act_mask_nxt;
  logic [NP-1:0]   pins_r, pins_nxt;

  logic [TW-1:0] rem_r   [NP], rem_nxt   [NP];
  logic [TW-1:0] per_r   [NP], per_nxt   [NP];
  logic [7:0]    cyc_r   [NP], cyc_nxt   [NP];
  logic          phase_r [NP], phase_nxt [NP];
  logic [TW-1:0] hlim_r  [NP], hlim_nxt  [NP];
  logic [TW-1:0] hcnt_r  [NP], hcnt_nxt  [NP];

  gbiq_pkg::gbiq_in_t  item_r, item_nxt;
  logic                status_r, status_nxt;
  logic                qual_r, qual_nxt;
  logic                out_strobe_r;
  gbiq_pkg::gbiq_out_t out_data_r, out_data_nxt;

  logic [gbiq_pkg::IDX_W-1:0] addr;
  logic [AW-1:0]              ai;
  logic                       a_valid;
  gbiq_pkg::mode_t            mode_a;
  logic                       outp;
  logic                       act_a;
  logic [TW-1:0]              rem_dec;
  logic [TW-1:0]              hp_cut;
  logic [TW-1:0]              hold_cut;
  logic [15:0]                pins_vis;

  // One port is read and updated per cycle: the walk index or the request's port.
  assign addr    = cmd.walk ? cmd.idx : item_r.port;
  assign ai      = addr[AW-1:0];
  assign a_valid = (32'(addr) < NP);
  assign mode_a  = a_valid ? gbiq_pkg::mode_t'(port_mode_r[{ai, 1'b0} +: 2])
                           : gbiq_pkg::MODE_ABSENT;
  assign outp    = (mode_a == gbiq_pkg::MODE_OUT_INACT) || (mode_a == gbiq_pkg::MODE_OUT_ACT);
  assign act_a   = act_mask_r[ai];
  assign rem_dec = rem_r[ai] - 1'b1;
  assign hp_cut   = item_r.half_period[TW-1:0];
  assign hold_cut = item_r.hold_ticks[TW-1:0];

  always_comb begin
    pins_vis = '0;
    for (int i = 0; i < NP; i++) begin
      pins_vis[i] = pins_r[i] & port_mode_r[2*i+1];
    end
  end

  always_comb begin
    port_mode_nxt = port_mode_r;
    act_mask_nxt  = act_mask_r;
    pins_nxt      = pins_r;
    rem_nxt       = rem_r;
    per_nxt       = per_r;
    cyc_nxt       = cyc_r;
    phase_nxt     = phase_r;
    hlim_nxt      = hlim_r;
    hcnt_nxt      = hcnt_r;
    item_nxt      = item_r;
    status_nxt    = status_r;
    qual_nxt      = qual_r;
    out_data_nxt  = out_data_r;

    if (cfg_we) begin
      case (cfg_index)
        gbiq_pkg::REG_PORT_MODE:   port_mode_nxt = cfg_wdata[2*NP-1:0];
        gbiq_pkg::REG_ACTIVE_MASK: act_mask_nxt  = cfg_wdata[NP-1:0];
        default: ;
      endcase
    end

    if (cmd.load) begin
      item_nxt   = in_data;
      status_nxt = gbiq_pkg::STAT_OK;
      qual_nxt   = 1'b0;
    end

    if (cmd.step) begin
      case (item_r.action)
        gbiq_pkg::ACT_INIT: begin
          if (mode_a != gbiq_pkg::MODE_ABSENT) begin
            if (outp) begin
              pins_nxt[ai] = (mode_a == gbiq_pkg::MODE_OUT_ACT) ? act_a : ~act_a;
            end
            rem_nxt[ai]   = '0;
            per_nxt[ai]   = '0;
            cyc_nxt[ai]   = '0;
            phase_nxt[ai] = 1'b0;
          end
        end
        gbiq_pkg::ACT_SET_LEVEL: begin
          if (outp) begin
            pins_nxt[ai] = item_r.want_active ? act_a : ~act_a;
          end else begin
            status_nxt = gbiq_pkg::STAT_IGNORED;
          end
        end
        gbiq_pkg::ACT_BLINK_START: begin
          if (!outp) begin
            status_nxt = gbiq_pkg::STAT_IGNORED;
          end else if (per_r[ai] != hp_cut) begin
            rem_nxt[ai] = hp_cut;
            per_nxt[ai] = hp_cut;
            cyc_nxt[ai] = item_r.blink_count;
          end
        end
        gbiq_pkg::ACT_BLINK_STOP: begin
          if (outp) begin
            rem_nxt[ai]   = '0;
            per_nxt[ai]   = '0;
            cyc_nxt[ai]   = '0;
            phase_nxt[ai] = 1'b0;
            pins_nxt[ai]  = ~act_a;
          end else begin
            status_nxt = gbiq_pkg::STAT_IGNORED;
          end
        end
        gbiq_pkg::ACT_TICK: begin
          if (outp && rem_r[ai] != '0 && cyc_r[ai] != '0) begin
            if (rem_dec == '0) begin
              // A full on-off cycle ends on the toggle out of phase one.
              if (phase_r[ai]) begin
                if (cyc_r[ai] != gbiq_pkg::FOREVER) begin
                  cyc_nxt[ai] = cyc_r[ai] - 1'b1;
                end
                phase_nxt[ai] = 1'b0;
              end else begin
                phase_nxt[ai] = 1'b1;
              end
              rem_nxt[ai]  = per_r[ai];
              pins_nxt[ai] = ~pins_r[ai];
            end else begin
              rem_nxt[ai] = rem_dec;
            end
          end
        end
        gbiq_pkg::ACT_SET_HOLD: begin
          if (mode_a == gbiq_pkg::MODE_INPUT) begin
            hlim_nxt[ai] = hold_cut;
          end else begin
            status_nxt = gbiq_pkg::STAT_IGNORED;
          end
        end
        gbiq_pkg::ACT_POLL: begin
          if (mode_a != gbiq_pkg::MODE_INPUT) begin
            status_nxt = gbiq_pkg::STAT_IGNORED;
          end else begin
            pins_nxt[ai] = item_r.pin_level;
            if (item_r.pin_level != act_a) begin
              hcnt_nxt[ai] = '0;
            end else if (hcnt_r[ai] < hlim_r[ai]) begin
              hcnt_nxt[ai] = hcnt_r[ai] + 1'b1;
            end else begin
              qual_nxt = 1'b1;
            end
          end
        end
        default: begin
          status_nxt = gbiq_pkg::STAT_IGNORED;
        end
      endcase
    end

    if (cmd.report) begin
      out_data_nxt.pins_out  = pins_vis;
      out_data_nxt.status    = status_r;
      out_data_nxt.qualified = qual_r;
      if (mode_a == gbiq_pkg::MODE_ABSENT) begin
        out_data_nxt.port_state = gbiq_pkg::PST_ABSENT;
      end else if (pins_r[ai] == act_a) begin
        out_data_nxt.port_state = gbiq_pkg::PST_ACTIVE;
      end else begin
        out_data_nxt.port_state = gbiq_pkg::PST_INACTIVE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_mode_r  <= '0;
      act_mask_r   <= '0;
      pins_r       <= '0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < NP; i++) begin
        rem_r[i]   <= '0;
        per_r[i]   <= '0;
        cyc_r[i]   <= '0;
        phase_r[i] <= 1'b0;
        hlim_r[i]  <= '0;
        hcnt_r[i]  <= '0;
      end
    end else begin
      port_mode_r  <= port_mode_nxt;
      act_mask_r   <= act_mask_nxt;
      pins_r       <= pins_nxt;
      out_strobe_r <= cmd.report;
      rem_r        <= rem_nxt;
      per_r        <= per_nxt;
      cyc_r        <= cyc_nxt;
      phase_r      <= phase_nxt;
      hlim_r       <= hlim_nxt;
      hcnt_r       <= hcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    status_r   <= status_nxt;
    qual_r     <= qual_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("result strobe held for more than one cycle");

  a_walk_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && (item_r.action == gbiq_pkg::ACT_INIT ||
                      item_r.action == gbiq_pkg::ACT_TICK))
      |-> (out_data_r.status == gbiq_pkg::STAT_OK) && !out_data_r.qualified)
    else $error("init or tick reported ignored or qualified");

  a_qual_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_data_r.qualified)
      |-> (out_data_r.status == gbiq_pkg::STAT_OK) &&
          (out_data_r.port_state == gbiq_pkg::PST_ACTIVE))
    else $error("qualified input not reported active and accepted");

endmodule

FILE: hw/rtl/gpio_blink_and_input_qualifier.sv
// ----------------------------------------------------------------------------
// gpio_blink_and_input_qualifier
// Multi-port GPIO with blinking outputs and hold-time qualified inputs.
// The result strobe is registered from REPORT, which follows SINGLE for a
// plain request, or for init and tick a walk of min(NUM_PORTS,16) ports that
// visits one port per cycle through the shared per-port register update.
// busy drops in the cycle of the strobe, so a new request is taken then.
// Reset clears configuration, pin levels and all blink and hold state.
// ----------------------------------------------------------------------------
module gpio_blink_and_input_qualifier #(
  parameter int NUM_PORTS = 16,
  parameter int TIME_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  gbiq_pkg::gbiq_in_t             in_data,
  output logic                           out_strobe,
  output gbiq_pkg::gbiq_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [gbiq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);

  gbiq_pkg::gbiq_cmd_t cmd;

  gbiq_ctrl #(
    .NUM_PORTS (NUM_PORTS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_data.action),
    .busy   (busy),
    .cmd    (cmd)
  );

  gbiq_datapath #(
    .NUM_PORTS (NUM_PORTS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
